### src/rmr_pkg.sv
// Shared types and constants for the row max-metric resampler.
// Used by every module of the block; depends on nothing.
package rmr_pkg;

	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;
	localparam int CH_W      = 8;
	localparam int METRIC_W  = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_WIDTH  = 1'b0,
		REG_OUT_WIDTH = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] a;
	} pixel_t;

	typedef struct packed {
		logic [CFG_W-1:0] in_width;
		logic [CFG_W-1:0] out_width;
		logic             bad;
		logic             restart;
	} cfg_t;

	typedef struct packed {
		pixel_t pix;
		logic   last_of_run;
		logic   row_done;
		logic   config_error;
	} result_t;

endpackage

### src/row_max_metric_resampler_unit.sv
// Row max-metric resampler: resizes RGBA rows from in_width to out_width
// pixels, keeping the brightest pixel of each window.
// Depends on rmr_pkg, rmr_cfg_regs, rmr_window_engine and rmr_out_reg.
//
// Usage:
//  - Input channel (in_valid/in_stall) takes one pixel per transaction, rows
//    left to right. Output channel (out_valid/out_stall) gives result pixels.
//  - A pixel sits in the input register and yields zero to MAX_UPSCALE
//    results, one per cycle through the single result port unless the
//    output stalls. Downscaling or 1:1 sustains one pixel per cycle unless
//    the output stalls; a pixel that closes more than one window holds the
//    input until its last result is taken.
//  - A pixel's first result passes the input, then the output register.
//  - A stalled output holds its transaction; the engine waits and the input
//    register fills, after which in_stall rises.
//  - Writing either width register restarts the row. Write only when idle.
//  - A bad configuration gives one result per pixel with config_error set.
//  - Reset empties both registers, sets both widths to 1 and starts a new row.
module row_max_metric_resampler_unit #(
	parameter int MAX_WIDTH   = 4096,
	parameter int MAX_UPSCALE = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rmr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rmr_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rmr_pkg::CH_W-1:0]      red,
	input  logic [rmr_pkg::CH_W-1:0]      green,
	input  logic [rmr_pkg::CH_W-1:0]      blue,
	input  logic [rmr_pkg::CH_W-1:0]      alpha,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rmr_pkg::CH_W-1:0]      out_red,
	output logic [rmr_pkg::CH_W-1:0]      out_green,
	output logic [rmr_pkg::CH_W-1:0]      out_blue,
	output logic [rmr_pkg::CH_W-1:0]      out_alpha,
	output logic                          last_of_run,
	output logic                          row_done,
	output logic                          config_error
);
	import rmr_pkg::*;

	cfg_t    cfg;
	logic    valid_s1;
	pixel_t  pix_s1;
	logic    accept;
	logic    item_done;
	logic    res_valid;
	result_t res;
	logic    out_ready;
	result_t out_q;

	rmr_cfg_regs #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_UPSCALE (MAX_UPSCALE)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign in_stall = valid_s1 && !item_done;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (item_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= '{r: red, g: green, b: blue, a: alpha};
		end
	end

	rmr_window_engine #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_UPSCALE (MAX_UPSCALE)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (valid_s1),
		.item_pix   (pix_s1),
		.out_ready  (out_ready),
		.res_valid  (res_valid),
		.res        (res),
		.item_done  (item_done)
	);

	rmr_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_valid),
		.d      (res),
		.stall  (out_stall),
		.ready  (out_ready),
		.valid  (out_valid),
		.q      (out_q)
	);

	assign out_red      = out_q.pix.r;
	assign out_green    = out_q.pix.g;
	assign out_blue     = out_q.pix.b;
	assign out_alpha    = out_q.pix.a;
	assign last_of_run  = out_q.last_of_run;
	assign row_done     = out_q.row_done;
	assign config_error = out_q.config_error;

`ifndef SYNTHESIS
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && config_error |-> last_of_run && !row_done &&
		out_red == '0 && out_green == '0 && out_blue == '0 && out_alpha == '0)
		else $error("error result carries pixel data or wrong flags");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_ready && valid_s1)
		else $error("result produced while output register is full or no pixel held");

	a_done_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_done |-> valid_s1)
		else $error("pixel retired from an empty input register");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted pixel lost from input register");
`endif

endmodule

### src/rmr_cfg_regs.sv
// Width registers and configuration check for the row resampler.
// Depends on rmr_pkg.
module rmr_cfg_regs #(
	parameter int MAX_WIDTH   = 4096,
	parameter int MAX_UPSCALE = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rmr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rmr_pkg::CFG_W-1:0]      cfg_data,
	output rmr_pkg::cfg_t                  cfg
);
	import rmr_pkg::*;

	logic [CFG_W-1:0] in_width_q;
	logic [CFG_W-1:0] out_width_q;
	logic [31:0]      iw_ext;
	logic [31:0]      ow_ext;
	logic [31:0]      iw_scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q  <= CFG_W'(1);
			out_width_q <= CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IN_WIDTH:  in_width_q  <= cfg_data;
				REG_OUT_WIDTH: out_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign iw_ext    = 32'(in_width_q);
	assign ow_ext    = 32'(out_width_q);
	assign iw_scaled = iw_ext * 32'(MAX_UPSCALE);

	always_comb begin
		cfg.in_width  = in_width_q;
		cfg.out_width = out_width_q;
		cfg.restart   = cfg_we;
		cfg.bad       = (iw_ext == 32'd0) || (ow_ext == 32'd0) ||
		                (iw_ext > 32'(MAX_WIDTH)) || (ow_ext > 32'(MAX_WIDTH)) ||
		                (ow_ext > iw_scaled);
	end

endmodule

### src/rmr_window_engine.sv
// Window tracking and max-metric selection, one result per cycle while the output register is ready.
// Holds the row position state; depends on rmr_pkg.
module rmr_window_engine #(
	parameter int MAX_WIDTH   = 4096,
	parameter int MAX_UPSCALE = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rmr_pkg::cfg_t    cfg,
	input  logic             item_valid,
	input  rmr_pkg::pixel_t  item_pix,
	input  logic             out_ready,
	output logic             res_valid,
	output rmr_pkg::result_t res,
	output logic             item_done
);
	import rmr_pkg::*;

	localparam int CFG_MAX = (1 << CFG_W) - 1;
	localparam int LIM     = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
	localparam int CNT_W   = $clog2(LIM + 1);
	localparam int ACC_W   = 2 * CNT_W + 1;
	localparam int RUN_W   = $clog2(MAX_UPSCALE + 1);

	logic [CNT_W-1:0]    in_col_q;
	logic [CNT_W-1:0]    out_col_q;
	logic [ACC_W-1:0]    in_acc_q;
	logic [ACC_W-1:0]    out_acc_q;
	logic [METRIC_W-1:0] best_metric_q;
	pixel_t              best_pix_q;
	logic                win_open_q;
	logic [RUN_W-1:0]    run_q;

	logic [CNT_W-1:0]    iw_c;
	logic [CNT_W-1:0]    ow_c;
	logic [ACC_W-1:0]    iw_a;
	logic [ACC_W-1:0]    ow_a;
	logic [ACC_W-1:0]    cur1;
	logic [ACC_W-1:0]    cur2;
	logic [ACC_W-1:0]    jn;
	logic [ACC_W-1:0]    jn2;
	logic [METRIC_W-1:0] metric;
	logic [CNT_W-1:0]    out_col_inc;
	logic [CNT_W-1:0]    in_col_inc;
	logic [RUN_W-1:0]    run_inc;
	logic                active;
	logic                reach;
	logic                take;
	logic                want_emit;
	logic                more;
	logic                emit_fire;
	logic                upd_fire;
	logic                row_end;

	assign iw_c = cfg.in_width[CNT_W-1:0];
	assign ow_c = cfg.out_width[CNT_W-1:0];
	assign iw_a = ACC_W'(iw_c);
	assign ow_a = ACC_W'(ow_c);

	// cur1/cur2: right edges of this column and the next, scaled by out_width
	assign cur1 = in_acc_q + ow_a;
	assign cur2 = in_acc_q + (ow_a << 1);
	assign jn   = out_acc_q + iw_a;
	assign jn2  = out_acc_q + (iw_a << 1);

	assign metric = METRIC_W'(item_pix.r) + METRIC_W'(item_pix.g) + METRIC_W'(item_pix.b);

	assign out_col_inc = out_col_q + CNT_W'(1);
	assign in_col_inc  = in_col_q + CNT_W'(1);
	assign run_inc     = run_q + RUN_W'(1);

	assign active    = (out_col_q < ow_c) && (run_q < RUN_W'(MAX_UPSCALE)) && (out_acc_q < cur1);
	assign reach     = jn >= cur1;
	assign take      = !win_open_q || (metric > best_metric_q);
	assign want_emit = active && !(reach && (jn >= cur2));
	// another window closes on this same pixel
	assign more      = (out_col_inc < ow_c) && (run_inc < RUN_W'(MAX_UPSCALE)) &&
	                   (jn < cur1) && (jn2 < cur2);

	always_comb begin
		res_valid = 1'b0;
		item_done = 1'b0;
		if (item_valid) begin
			if (cfg.bad) begin
				res_valid = out_ready;
				item_done = out_ready;
			end else if (want_emit) begin
				res_valid = out_ready;
				item_done = out_ready && !more;
			end else begin
				item_done = 1'b1;
			end
		end
	end

	assign emit_fire = item_valid && !cfg.bad && want_emit && out_ready;
	assign upd_fire  = item_valid && !cfg.bad && active && reach && take &&
	                   (emit_fire || !want_emit);
	assign row_end   = in_col_inc >= iw_c;

	always_comb begin
		res.pix          = '0;
		res.last_of_run  = 1'b1;
		res.row_done     = 1'b0;
		res.config_error = cfg.bad;
		if (!cfg.bad) begin
			res.pix         = (reach && !take) ? best_pix_q : item_pix;
			res.last_of_run = !more;
			res.row_done    = out_col_inc == ow_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q      <= '0;
			out_col_q     <= '0;
			in_acc_q      <= '0;
			out_acc_q     <= '0;
			best_metric_q <= '0;
			best_pix_q    <= '0;
			win_open_q    <= 1'b0;
			run_q         <= '0;
		end else if (cfg.restart) begin
			in_col_q      <= '0;
			out_col_q     <= '0;
			in_acc_q      <= '0;
			out_acc_q     <= '0;
			best_metric_q <= '0;
			best_pix_q    <= '0;
			win_open_q    <= 1'b0;
			run_q         <= '0;
		end else if (item_valid && !cfg.bad) begin
			if (item_done && row_end) begin
				in_col_q      <= '0;
				out_col_q     <= '0;
				in_acc_q      <= '0;
				out_acc_q     <= '0;
				best_metric_q <= '0;
				best_pix_q    <= '0;
				win_open_q    <= 1'b0;
				run_q         <= '0;
			end else begin
				if (upd_fire) begin
					best_pix_q <= item_pix;
				end
				if (emit_fire) begin
					out_col_q     <= out_col_inc;
					out_acc_q     <= jn;
					win_open_q    <= 1'b0;
					best_metric_q <= '0;
				end else if (upd_fire) begin
					best_metric_q <= metric;
					win_open_q    <= 1'b1;
				end
				if (item_done) begin
					run_q    <= '0;
					in_col_q <= in_col_inc;
					in_acc_q <= cur1;
				end else if (emit_fire) begin
					run_q <= run_inc;
				end
			end
		end
	end

endmodule

### src/rmr_out_reg.sv
// Output register of the row resampler: holds one result transaction.
// Depends on rmr_pkg.
module rmr_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  rmr_pkg::result_t d,
	input  logic             stall,
	output logic             ready,
	output logic             valid,
	output rmr_pkg::result_t q
);
	import rmr_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign ready = !valid_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			data_q <= d;
		end
	end

	assign valid = valid_q;
	assign q     = data_q;

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for row_max_metric_resampler_unit: directed and random pixel rows
// checked against a built-in row resampling predictor. Depends on rmr_pkg and
// the RTL under src/.
module testbench;
	import rmr_pkg::*;

	localparam int MAX_W     = 4096;
	localparam int UPSCALE   = 16;
	localparam int LONG_HOLD = 80;
	localparam int SETTLE    = 8;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	cfg_reg_t         cfg_index = REG_IN_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [CH_W-1:0]  red = '0, green = '0, blue = '0, alpha = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [CH_W-1:0]  out_red, out_green, out_blue, out_alpha;
	logic             last_of_run, row_done, config_error;

	row_max_metric_resampler_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.red(red), .green(green), .blue(blue), .alpha(alpha),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue), .out_alpha(out_alpha),
		.last_of_run(last_of_run), .row_done(row_done), .config_error(config_error)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [CFG_W-1:0] width_in = 13'd1, width_out = 13'd1;
	int unsigned      col_in, col_out, acc_in, acc_out, best_metric;
	pixel_t           best_px = '0;
	bit               win_open;

	pixel_t  pending_pixels[$];
	result_t due_results[$];
	pixel_t  next_px;
	bit      px_accepted;
	bit      steady, hold_arm, hold_used;
	int      tx_gap, stall_left, mismatches;

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (steady) return 0;
		if (p < 55) return 0;
		if (p < 88) return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t px;
		if ($urandom_range(0, 3) == 0) begin
			// narrow channels make metric ties frequent
			px.r = $urandom_range(0, 2);
			px.g = $urandom_range(0, 2);
			px.b = $urandom_range(0, 2);
		end else begin
			px.r = $urandom_range(0, 255);
			px.g = $urandom_range(0, 255);
			px.b = $urandom_range(0, 255);
		end
		px.a = $urandom_range(0, 255);
		return px;
	endfunction

	function void restart_row();
		col_in = 0;
		col_out = 0;
		acc_in = 0;
		acc_out = 0;
		best_metric = 0;
		best_px = '0;
		win_open = 1'b0;
	endfunction

	task automatic resample_pixel(input pixel_t px);
		int unsigned m, iw, ow, cur1, cur2, jb, jn;
		result_t     res;
		result_t     run[$];
		pixel_t      pick;
		bit          stop;
		m = 32'(px.r) + 32'(px.g) + 32'(px.b);
		iw = width_in;
		ow = width_out;
		if (iw == 0 || ow == 0 || iw > MAX_W || ow > MAX_W || ow > UPSCALE * iw) begin
			res = '0;
			res.last_of_run = 1'b1;
			res.config_error = 1'b1;
			due_results.push_back(res);
			return;
		end
		cur1 = acc_in + ow;
		cur2 = cur1 + ow;
		stop = 1'b0;
		while (!stop && col_out < ow && run.size() < UPSCALE) begin
			jb = acc_out;
			jn = jb + iw;
			pick = px;
			if (jb >= cur1) begin
				stop = 1'b1;
			end else if (jn >= cur1) begin
				if (!win_open || m > best_metric) begin
					best_px = px;
					best_metric = m;
					win_open = 1'b1;
				end
				if (jn >= cur2)
					stop = 1'b1;
				pick = best_px;
			end
			if (!stop) begin
				res = '0;
				res.pix = pick;
				res.row_done = (col_out + 1 == ow);
				run.push_back(res);
				col_out++;
				acc_out = jn;
				win_open = 1'b0;
				best_metric = 0;
			end
		end
		if (run.size() > 0)
			run[run.size() - 1].last_of_run = 1'b1;
		foreach (run[k])
			due_results.push_back(run[k]);
		col_in++;
		acc_in = cur1;
		if (col_in >= iw)
			restart_row();
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !px_accepted) begin
			// hold the stalled transaction
		end else if (tx_gap > 0) begin
			in_valid <= 1'b0;
			tx_gap <= tx_gap - 1;
		end else if (pending_pixels.size() > 0) begin
			next_px = pending_pixels.pop_front();
			red <= next_px.r;
			green <= next_px.g;
			blue <= next_px.b;
			alpha <= next_px.a;
			in_valid <= 1'b1;
			tx_gap <= pick_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_arm && !hold_used) begin
			out_stall <= 1'b1;
			stall_left <= LONG_HOLD;
			hold_used <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			stall_left <= pick_gap();
		end
	end

	// prediction and result check
	always @(posedge clk) begin
		result_t want;
		px_accepted = arst_n && in_valid && !in_stall;
		if (px_accepted)
			resample_pixel(pixel_t'{red, green, blue, alpha});
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				$error("unexpected result transaction: no expectation pending");
				mismatches++;
			end else begin
				want = due_results.pop_front();
				check_field("out_red", want.pix.r, out_red);
				check_field("out_green", want.pix.g, out_green);
				check_field("out_blue", want.pix.b, out_blue);
				check_field("out_alpha", want.pix.a, out_alpha);
				check_field("last_of_run", want.last_of_run, last_of_run);
				check_field("row_done", want.row_done, row_done);
				check_field("config_error", want.config_error, config_error);
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_IN_WIDTH)
			width_in = value;
		else
			width_out = value;
		restart_row();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// sampled at the rising edge, where the sender's outputs are stable
	task automatic drain();
		while (pending_pixels.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic run_rows(input int iw, input int ow, input int count);
		write_reg(REG_IN_WIDTH, CFG_W'(iw));
		write_reg(REG_OUT_WIDTH, CFG_W'(ow));
		repeat (count) pending_pixels.push_back(rand_pixel());
		drain();
	endtask

	initial begin
		int sent, sel, iw, ow, count;
		restart_row();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// 4 -> 2: extremes, ties keep the earlier pixel, max in second column
		write_reg(REG_IN_WIDTH, 13'd4);
		write_reg(REG_OUT_WIDTH, 13'd2);
		pending_pixels.push_back(pixel_t'{8'd0, 8'd0, 8'd0, 8'd0});
		pending_pixels.push_back(pixel_t'{8'd255, 8'd255, 8'd255, 8'd255});
		pending_pixels.push_back(pixel_t'{8'd10, 8'd20, 8'd30, 8'd7});
		pending_pixels.push_back(pixel_t'{8'd30, 8'd20, 8'd10, 8'd9});
		pending_pixels.push_back(pixel_t'{8'd1, 8'd2, 8'd3, 8'd4});
		pending_pixels.push_back(pixel_t'{8'd200, 8'd0, 8'd0, 8'd1});
		pending_pixels.push_back(pixel_t'{8'd0, 8'd0, 8'd0, 8'd255});
		pending_pixels.push_back(pixel_t'{8'd0, 8'd0, 8'd0, 8'd0});
		drain();

		// 3 -> 7: upscaling with empty windows
		write_reg(REG_IN_WIDTH, 13'd3);
		write_reg(REG_OUT_WIDTH, 13'd7);
		pending_pixels.push_back(pixel_t'{8'd255, 8'd0, 8'd255, 8'd128});
		pending_pixels.push_back(pixel_t'{8'd0, 8'd255, 8'd0, 8'd1});
		pending_pixels.push_back(pixel_t'{8'd17, 8'd34, 8'd51, 8'd68});
		drain();

		// most results per pixel
		run_rows(1, 16, 2);

		// unusable settings
		run_rows(1, 17, 1);
		run_rows(5, 0, 1);
		run_rows(0, 3, 1);
		run_rows(8191, 1, 1);
		run_rows(4096, 5000, 1);

		// widest rows; the second gives no results
		run_rows(4096, 4096, 3);
		run_rows(4096, 1, 2);

		// long output hold with the sender streaming, then a full drain mid-row
		steady = 1'b1;
		write_reg(REG_IN_WIDTH, 13'd8);
		write_reg(REG_OUT_WIDTH, 13'd8);
		repeat (16) pending_pixels.push_back(rand_pixel());
		hold_arm = 1'b1;
		drain();
		steady = 1'b0;
		repeat (12) pending_pixels.push_back(rand_pixel());
		drain();

		sent = 0;
		while (sent < 120) begin
			sel = $urandom_range(0, 9);
			steady = ($urandom_range(0, 3) == 0);
			if (sel == 0) begin
				case ($urandom_range(0, 3))
					0: begin iw = 0; ow = $urandom_range(1, 100); end
					1: begin iw = $urandom_range(1, 100); ow = 0; end
					2: begin iw = $urandom_range(1, 50); ow = 16 * iw + $urandom_range(1, 20); end
					default: begin iw = $urandom_range(4097, 8191); ow = $urandom_range(1, 4096); end
				endcase
				count = 3;
			end else begin
				if (sel <= 3) begin
					iw = $urandom_range(2, 16);
					ow = $urandom_range(1, iw);
				end else if (sel <= 6) begin
					iw = $urandom_range(1, 6);
					ow = $urandom_range(iw, (16 * iw < 24) ? 16 * iw : 24);
				end else begin
					iw = $urandom_range(1, 3);
					ow = ($urandom_range(0, 1) == 0) ? 16 * iw : iw;
				end
				count = iw * $urandom_range(1, 3) + $urandom_range(0, iw - 1);
			end
			run_rows(iw, ow, count);
			sent += count;
		end
		steady = 1'b0;
		drain();

		if (mismatches == 0 && due_results.size() == 0)
			$display("row_max_metric_resampler_unit test passed");
		else
			$display("row_max_metric_resampler_unit test failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("row_max_metric_resampler_unit test failed");
		$finish;
	end

endmodule
